// File: rtl/mct_pkg.sv
`default_nettype none
package mct_pkg;

  // result queue depth, must be at least two
  localparam int unsigned FIFO_DEPTH_DEF = 4;

  localparam int unsigned LINE_W = 20;
  localparam int unsigned COL_W  = 16;

  localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
  localparam logic [COL_W-1:0]  COL_MAX  = {COL_W{1'b1}};

  // event kinds
  localparam logic [1:0] EV_TEXT = 2'd0;
  localparam logic [1:0] EV_END  = 2'd1;
  localparam logic [1:0] EV_ERR  = 2'd2;
  localparam logic [1:0] EV_EOS  = 2'd3;

  // token types
  localparam logic [3:0] TT_COLON  = 4'd0;
  localparam logic [3:0] TT_COMMA  = 4'd1;
  localparam logic [3:0] TT_EQUAL  = 4'd2;
  localparam logic [3:0] TT_LPAREN = 4'd3;
  localparam logic [3:0] TT_RPAREN = 4'd4;
  localparam logic [3:0] TT_LBRACK = 4'd5;
  localparam logic [3:0] TT_RBRACK = 4'd6;
  localparam logic [3:0] TT_LBRACE = 4'd7;
  localparam logic [3:0] TT_RBRACE = 4'd8;
  localparam logic [3:0] TT_STRING = 4'd9;
  localparam logic [3:0] TT_NUMBER = 4'd10;
  localparam logic [3:0] TT_IDENT  = 4'd11;
  localparam logic [3:0] TT_UNDEF  = 4'd12;
  localparam logic [3:0] TT_NONE   = 4'd0;

  // error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_SYMBOL = 2'd1;
  localparam logic [1:0] ERR_STRING = 2'd2;
  localparam logic [1:0] ERR_NUMBER = 2'd3;

  // characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_LINE   = 3'd1,
    MODE_BLOCK  = 3'd2,
    MODE_STRING = 3'd3,
    MODE_NUMBER = 3'd4,
    MODE_IDENT  = 3'd5,
    MODE_AT     = 3'd6
  } mode_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        event_kind;
    logic [3:0]        token_type;
    logic [7:0]        text_char;
    logic [LINE_W-1:0] line_no;
    logic [COL_W-1:0]  start_column;
    logic [1:0]        error_code;
    logic              last_of_run;
  } out_item_t;

  // results caused by one character, in order
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } lex_res_t;

  function automatic out_item_t mk_res(input logic [1:0]        kind,
                                       input logic [3:0]        ttype,
                                       input logic [7:0]        ch,
                                       input logic [LINE_W-1:0] line,
                                       input logic [COL_W-1:0]  col,
                                       input logic [1:0]        err);
    out_item_t r;
    r.event_kind   = kind;
    r.token_type   = ttype;
    r.text_char    = ch;
    r.line_no      = line;
    r.start_column = col;
    r.error_code   = err;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
           is_digit(c) || (c == CH_UNDER) || (c == CH_DOT);
  endfunction

  // bit 4 flags a punctuation character, low bits carry its token type
  function automatic logic [4:0] punct_type(input logic [7:0] c);
    logic [4:0] r;
    case (c)
      CH_COLON:  r = {1'b1, TT_COLON};
      CH_COMMA:  r = {1'b1, TT_COMMA};
      CH_EQUAL:  r = {1'b1, TT_EQUAL};
      CH_LPAREN: r = {1'b1, TT_LPAREN};
      CH_RPAREN: r = {1'b1, TT_RPAREN};
      CH_LBRACK: r = {1'b1, TT_LBRACK};
      CH_RBRACK: r = {1'b1, TT_RBRACK};
      CH_LBRACE: r = {1'b1, TT_LBRACE};
      CH_RBRACE: r = {1'b1, TT_RBRACE};
      default:   r = {1'b0, TT_NONE};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/mct_lexer.sv
`default_nettype none
module mct_lexer
  import mct_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     accept,
  input  wire in_item_t item,
  output lex_res_t      res
);

  mode_t             mode_r,  mode_nxt;
  logic [7:0]        prev_r,  prev_nxt;
  logic              slash_r, slash_nxt;
  logic [1:0]        dots_r,  dots_nxt;
  logic [LINE_W-1:0] line_r,  line_nxt;
  logic [COL_W-1:0]  col_r,   col_nxt;
  logic [COL_W-1:0]  tst_r,   tst_nxt;

  logic [7:0] c;
  assign c = item.char_in;

  // decode of a character seen outside any token
  logic       i_res_v;
  out_item_t  i_res;
  mode_t      i_mode;
  logic       i_slash;
  logic       i_tst_we;
  logic       i_dot_clr;
  logic [4:0] pt;

  assign pt = punct_type(c);

  always_comb begin
    i_res_v   = 1'b0;
    i_res     = mk_res(EV_ERR, TT_UNDEF, CH_NUL, line_r, col_r, ERR_SYMBOL);
    i_mode    = MODE_IDLE;
    i_slash   = 1'b0;
    i_tst_we  = 1'b0;
    i_dot_clr = 1'b0;
    if (is_space(c)) begin
      i_mode = MODE_IDLE;
    end else if (c == CH_HASH) begin
      i_mode = MODE_LINE;
    end else if (c == CH_SLASH) begin
      i_slash  = 1'b1;
      i_tst_we = 1'b1;
    end else if (pt[4]) begin
      i_res_v = 1'b1;
      i_res   = mk_res(EV_END, pt[3:0], CH_NUL, line_r, col_r, ERR_NONE);
    end else begin
      i_tst_we = 1'b1;
      if (c == CH_AT) begin
        i_mode = MODE_AT;
      end else if (c == CH_QUOTE) begin
        i_mode = MODE_STRING;
      end else if (is_digit(c)) begin
        i_mode    = MODE_NUMBER;
        i_dot_clr = 1'b1;
        i_res_v   = 1'b1;
        i_res     = mk_res(EV_TEXT, TT_NUMBER, c, line_r, col_r, ERR_NONE);
      end else if (is_ident(c)) begin
        i_mode  = MODE_IDENT;
        i_res_v = 1'b1;
        i_res   = mk_res(EV_TEXT, TT_IDENT, c, line_r, col_r, ERR_NONE);
      end else begin
        i_res_v = 1'b1;
      end
    end
  end

  out_item_t num_fin;
  assign num_fin = (dots_r > 2'd1) ?
                   mk_res(EV_ERR, TT_NUMBER, CH_NUL, line_r, tst_r, ERR_NUMBER) :
                   mk_res(EV_END, TT_NUMBER, CH_NUL, line_r, tst_r, ERR_NONE);

  logic num_cont;
  assign num_cont = is_digit(c) || (c == CH_DOT);

  // next state
  always_comb begin
    mode_nxt  = mode_r;
    prev_nxt  = c;
    slash_nxt = slash_r;
    dots_nxt  = dots_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    tst_nxt   = tst_r;
    if (item.end_of_input) begin
      mode_nxt  = MODE_IDLE;
      prev_nxt  = CH_NUL;
      slash_nxt = 1'b0;
      dots_nxt  = 2'd0;
      line_nxt  = LINE_W'(1);
      col_nxt   = '0;
      tst_nxt   = '0;
    end else begin
      case (mode_r)
        MODE_LINE: begin
          if (c == CH_NL) mode_nxt = MODE_IDLE;
        end
        MODE_BLOCK: begin
          if ((c == CH_SLASH) && (prev_r == CH_STAR)) mode_nxt = MODE_IDLE;
        end
        MODE_STRING: begin
          if ((c == CH_QUOTE) && (prev_r != CH_BSLASH)) mode_nxt = MODE_IDLE;
        end
        MODE_NUMBER: begin
          if (num_cont) begin
            if ((c == CH_DOT) && (dots_r < 2'd2)) dots_nxt = dots_r + 2'd1;
          end else begin
            mode_nxt  = i_mode;
            slash_nxt = i_slash;
            if (i_tst_we) tst_nxt = col_r;
            if (i_dot_clr) dots_nxt = 2'd0;
          end
        end
        MODE_IDENT: begin
          if (!is_ident(c)) begin
            mode_nxt  = i_mode;
            slash_nxt = i_slash;
            if (i_tst_we) tst_nxt = col_r;
            if (i_dot_clr) dots_nxt = 2'd0;
          end
        end
        MODE_AT: begin
          if (is_space(c)) mode_nxt = MODE_IDLE;
        end
        default: begin
          mode_nxt = MODE_IDLE;
          if (slash_r) begin
            slash_nxt = 1'b0;
            if (c == CH_SLASH) begin
              mode_nxt = MODE_LINE;
            end else if (c == CH_STAR) begin
              mode_nxt = MODE_BLOCK;
              prev_nxt = CH_NUL;
            end else begin
              mode_nxt  = i_mode;
              slash_nxt = i_slash;
              if (i_tst_we) tst_nxt = col_r;
              if (i_dot_clr) dots_nxt = 2'd0;
            end
          end else begin
            mode_nxt  = i_mode;
            slash_nxt = i_slash;
            if (i_tst_we) tst_nxt = col_r;
            if (i_dot_clr) dots_nxt = 2'd0;
          end
        end
      endcase
      if (c == CH_NL) begin
        if (line_r != LINE_MAX) line_nxt = line_r + LINE_W'(1);
        col_nxt = '0;
      end else if (col_r != COL_MAX) begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  // results
  logic      f_v;
  out_item_t f_res;
  out_item_t eos;
  assign eos = mk_res(EV_EOS, TT_NONE, CH_NUL, line_r, col_r, ERR_NONE);

  always_comb begin
    res.count  = 2'd0;
    res.first  = eos;
    res.second = eos;
    f_v        = 1'b0;
    f_res      = eos;
    if (item.end_of_input) begin
      case (mode_r)
        MODE_IDLE: begin
          f_v   = slash_r;
          f_res = mk_res(EV_ERR, TT_UNDEF, CH_NUL, line_r, tst_r, ERR_SYMBOL);
        end
        MODE_STRING: begin
          f_v   = 1'b1;
          f_res = mk_res(EV_ERR, TT_STRING, CH_NUL, line_r, tst_r, ERR_STRING);
        end
        MODE_NUMBER: begin
          f_v   = 1'b1;
          f_res = num_fin;
        end
        MODE_IDENT: begin
          f_v   = 1'b1;
          f_res = mk_res(EV_END, TT_IDENT, CH_NUL, line_r, tst_r, ERR_NONE);
        end
        MODE_AT: begin
          f_v   = 1'b1;
          f_res = mk_res(EV_END, TT_UNDEF, CH_NUL, line_r, tst_r, ERR_NONE);
        end
        default: f_v = 1'b0;
      endcase
      if (f_v) begin
        res.first  = f_res;
        res.second = eos;
        res.count  = 2'd2;
      end else begin
        res.first = eos;
        res.count = 2'd1;
      end
    end else begin
      case (mode_r)
        MODE_LINE, MODE_BLOCK: res.count = 2'd0;
        MODE_STRING: begin
          res.count = 2'd1;
          if ((c == CH_QUOTE) && (prev_r != CH_BSLASH))
            res.first = mk_res(EV_END, TT_STRING, CH_NUL, line_r, tst_r, ERR_NONE);
          else
            res.first = mk_res(EV_TEXT, TT_STRING, c, line_r, tst_r, ERR_NONE);
        end
        MODE_NUMBER: begin
          if (num_cont) begin
            res.count = 2'd1;
            res.first = mk_res(EV_TEXT, TT_NUMBER, c, line_r, tst_r, ERR_NONE);
          end else begin
            res.first  = num_fin;
            res.second = i_res;
            res.count  = i_res_v ? 2'd2 : 2'd1;
          end
        end
        MODE_IDENT: begin
          if (is_ident(c)) begin
            res.count = 2'd1;
            res.first = mk_res(EV_TEXT, TT_IDENT, c, line_r, tst_r, ERR_NONE);
          end else begin
            res.first  = mk_res(EV_END, TT_IDENT, CH_NUL, line_r, tst_r, ERR_NONE);
            res.second = i_res;
            res.count  = i_res_v ? 2'd2 : 2'd1;
          end
        end
        MODE_AT: begin
          if (is_space(c)) begin
            res.count = 2'd1;
            res.first = mk_res(EV_END, TT_UNDEF, CH_NUL, line_r, tst_r, ERR_NONE);
          end
        end
        default: begin
          if (slash_r) begin
            if ((c != CH_SLASH) && (c != CH_STAR)) begin
              res.first  = mk_res(EV_ERR, TT_UNDEF, CH_NUL, line_r, tst_r, ERR_SYMBOL);
              res.second = i_res;
              res.count  = i_res_v ? 2'd2 : 2'd1;
            end
          end else begin
            res.first = i_res;
            res.count = i_res_v ? 2'd1 : 2'd0;
          end
        end
      endcase
    end
    if (res.count == 2'd1) res.first.last_of_run = 1'b1;
    if (res.count == 2'd2) res.second.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      prev_r  <= CH_NUL;
      slash_r <= 1'b0;
      dots_r  <= 2'd0;
      line_r  <= LINE_W'(1);
      col_r   <= '0;
      tst_r   <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      prev_r  <= prev_nxt;
      slash_r <= slash_nxt;
      dots_r  <= dots_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      tst_r   <= tst_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/mct_fifo.sv
`default_nettype none
module mct_fifo
  import mct_pkg::*;
#(
  parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire lex_res_t  push_res,
  output logic           room2,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] LIMIT = CW'(DEPTH - 2);
  localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);

  out_item_t     mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, wr1;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;
  logic [1:0]    n_push;

  assign pop       = out_valid && !out_stall;
  assign n_push    = push ? push_res.count : 2'd0;
  assign out_valid = (cnt_r != '0);
  assign room2     = (cnt_r <= LIMIT);
  assign out_item  = mem_r[rd_r];
  assign wr1       = (wr_r == LAST) ? '0 : wr_r + PW'(1);

  always_comb begin
    case (n_push)
      2'd1:    wr_nxt = wr1;
      2'd2:    wr_nxt = (wr1 == LAST) ? '0 : wr1 + PW'(1);
      default: wr_nxt = wr_r;
    endcase
    rd_nxt  = pop ? ((rd_r == LAST) ? '0 : rd_r + PW'(1)) : rd_r;
    cnt_nxt = cnt_r + CW'(n_push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) mem_r[wr_r] <= push_res.first;
    if (n_push == 2'd2) mem_r[wr1]  <= push_res.second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/markup_char_tokenizer_top.sv
// a result is written into the result queue when its character is accepted and is offered on out_ from there
// throughput: one character per cycle while the input is not stalled; a character that gives two
//   results sends them out one at a time, and the result queue absorbs such bursts
// input stalls while the result queue has fewer than two free entries
// reset: synchronous, active low; lexer state returns to line 1, column 0, queue empties
`default_nettype none
module markup_char_tokenizer_top
  import mct_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_item
);

  // transaction on the input side
  logic     in_accept;
  logic     room2;
  lex_res_t lex_res;

  // the queue must hold every result of a character before the character is taken
  assign in_stall  = !room2;
  assign in_accept = in_valid && !in_stall;

  // lexer state and per-character result decode
  mct_lexer u_lexer (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .item   (in_item),
    .res    (lex_res)
  );

  // result queue: up to two results written per cycle, one read per cycle while out_stall is low
  mct_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_res  (lex_res),
    .room2     (room2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
